>>> sv/epwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epwf_pkg
// Shared types and constants for the serial memory page write framer.
// ----------------------------------------------------------------------------
package epwf_pkg;

    // page size in bytes, a power of two
    localparam int PAGE_BYTES = 64;

    // command queue between classifier and byte sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // reset value of the bus device address register
    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd160;

    // kind of a bus byte, also the step of the byte sequencer
    typedef enum logic [1:0] {
        KIND_DEVICE  = 2'd0,
        KIND_ADDR_HI = 2'd1,
        KIND_ADDR_LO = 2'd2,
        KIND_DATA    = 2'd3
    } t_kind;

    // one classified data byte
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] addr;
        logic        hdr;
        logic        eot;
    } t_cmd;

    // queue head as seen by the sequencer
    typedef struct packed {
        t_cmd cmd;
        logic empty;
    } t_head;

endpackage

>>> sv/eeprom_page_write_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeprom_page_write_framer_unit
// Frames a stream of data bytes into page-bounded serial memory writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: queue-like, a transfer happens when push is high and full
//   is low. Each transfer carries one data byte with its first/last marks and
//   the start address (used only on a first byte).
//   Result channel: queue-like, the oldest result sits on the o_ ports while
//   empty is low and is transferred when pop is high.
//   Each input yields one data result, preceded by device, address high and
//   address low bytes when it opens a transaction.
//   The first result of an input passes through the command queue and then
//   the output register.
//   Throughput: one result per cycle while commands wait and the receiver
//   pops, set by the output register; a data byte inside a transaction yields
//   one result, a byte opening a transaction yields four. A four-entry command
//   queue absorbs header bursts, and input is taken while a result waits.
//   When the receiver stalls, results hold and the queue fills, then full
//   rises. Reset empties the queue, closes any transaction, clears the
//   address to zero and sets the device address to 160.
//   Configuration: i_cfg_we writes i_cfg_wdata into the device address.
// ----------------------------------------------------------------------------
module eeprom_page_write_framer_unit import epwf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_start_address,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_byte_kind,
    output logic        o_end_of_transaction,
    output logic        o_run_last
);

    logic [7:0] r_device_address;
    t_cmd       cmd;
    t_head      head;
    logic       take;
    logic       q_pop;

    // device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RESET;
        end else if (i_cfg_we) begin
            r_device_address <= i_cfg_wdata;
        end
    end

    assign take = push && !full;

    // classifier
    epwf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_start_address (i_start_address),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .o_cmd           (cmd)
    );

    // command queue
    epwf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_head  (head)
    );

    // byte sequencer
    epwf_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_device_address     (r_device_address),
        .i_head               (head),
        .o_pop                (q_pop),
        .o_empty              (empty),
        .i_pop                (pop),
        .o_out_byte           (o_out_byte),
        .o_byte_kind          (o_byte_kind),
        .o_end_of_transaction (o_end_of_transaction),
        .o_run_last           (o_run_last)
    );

endmodule

>>> sv/epwf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epwf_front
// Tracks the write address and open transaction, classifies each data byte.
// ----------------------------------------------------------------------------
module epwf_front import epwf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_start_address,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output t_cmd        o_cmd
);

    logic [15:0] r_next_addr, n_next_addr;
    logic        r_in_trans, n_in_trans;
    logic [15:0] addr;
    logic [15:0] following;
    logic        open;

    // classify the incoming byte
    always_comb begin
        addr      = i_first_byte ? i_start_address : r_next_addr;
        open      = i_first_byte ? 1'b0 : r_in_trans;
        following = addr + 16'd1;
        o_cmd.data = i_data_byte;
        o_cmd.addr = addr;
        o_cmd.hdr  = !open;
        o_cmd.eot  = i_last_byte || ((following % 16'(PAGE_BYTES)) == 16'd0);
    end

    // state update on a transfer
    always_comb begin
        n_next_addr = r_next_addr;
        n_in_trans  = r_in_trans;
        if (i_take) begin
            n_next_addr = following;
            n_in_trans  = !o_cmd.eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_addr <= 16'd0;
            r_in_trans  <= 1'b0;
        end else begin
            r_next_addr <= n_next_addr;
            r_in_trans  <= n_in_trans;
        end
    end

endmodule

>>> sv/epwf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epwf_queue
// Short command queue that decouples classification from byte sequencing.
// ----------------------------------------------------------------------------
module epwf_queue import epwf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output t_head o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic              do_push, do_pop;

    assign o_full        = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head.empty  = (r_count == '0);
    assign o_head.cmd    = r_mem[r_rptr];
    assign do_push       = i_push && !o_full;
    assign do_pop        = i_pop && !o_head.empty;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

>>> sv/epwf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epwf_back
// Expands each command into header and data bytes into an output register.
// ----------------------------------------------------------------------------
module epwf_back import epwf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_device_address,
    input  t_head      i_head,
    output logic       o_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_byte_kind,
    output logic       o_end_of_transaction,
    output logic       o_run_last
);

    t_kind      r_step, n_step;
    t_kind      cur_kind;
    logic       r_valid;
    logic       emit;
    logic [7:0] cur_byte;
    logic [7:0] r_byte;
    t_kind      r_kind;
    logic       r_eot;
    logic       r_last;

    // a byte moves into the output register when it is free or drained
    assign emit     = !i_head.empty && (!r_valid || i_pop);
    assign cur_kind = i_head.cmd.hdr ? r_step : KIND_DATA;

    // byte selection for the current step
    always_comb begin
        unique case (cur_kind)
            KIND_DEVICE:  cur_byte = i_device_address;
            KIND_ADDR_HI: cur_byte = i_head.cmd.addr[15:8];
            KIND_ADDR_LO: cur_byte = i_head.cmd.addr[7:0];
            KIND_DATA:    cur_byte = i_head.cmd.data;
            default:      cur_byte = i_head.cmd.data;
        endcase
    end

    // next step
    always_comb begin
        n_step = r_step;
        if (emit) begin
            unique case (cur_kind)
                KIND_DEVICE:  n_step = KIND_ADDR_HI;
                KIND_ADDR_HI: n_step = KIND_ADDR_LO;
                KIND_ADDR_LO: n_step = KIND_DATA;
                KIND_DATA:    n_step = KIND_DEVICE;
                default:      n_step = KIND_DEVICE;
            endcase
        end
    end

    // step outputs: the command retires with its data byte
    always_comb begin
        o_pop = emit && (cur_kind == KIND_DATA);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= KIND_DEVICE;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= cur_byte;
            r_kind <= cur_kind;
            r_eot  <= (cur_kind == KIND_DATA) && i_head.cmd.eot;
            r_last <= (cur_kind == KIND_DATA);
        end
    end

    assign o_empty              = !r_valid;
    assign o_out_byte           = r_byte;
    assign o_byte_kind          = r_kind;
    assign o_end_of_transaction = r_eot;
    assign o_run_last           = r_last;

endmodule
